// ===== hw/rtl/euler_zyz_rotation_matrix_core_defines.svh =====
// Assertion macros shared by the checker of the ZYZ rotation matrix core.
// Depends on nothing; the checker that includes it supplies clock and reset.
`ifndef EULER_ZYZ_ROTATION_MATRIX_CORE_DEFINES_SVH
`define EULER_ZYZ_ROTATION_MATRIX_CORE_DEFINES_SVH

// A stalled handshake keeps valid high and the payload steady.
`define EZYZ_ASSERT_HOLD(lbl, vld, rdy, dat) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (vld && !rdy) |=> (vld && $stable(dat))) else $error("stalled response changed");

// Property checked in the cycle after the trigger, reset included.
`define EZYZ_ASSERT_NEXT(lbl, trig, expr, msg) \
   lbl: assert property (@(posedge clock) trig |=> expr) else $error(msg);

// Property checked in the same cycle as the trigger, outside reset.
`define EZYZ_ASSERT_WHEN(lbl, trig, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) trig |-> expr) else $error(msg);

`endif

// ===== hw/rtl/ezyz_pkg.sv =====
// Package of the ZYZ rotation matrix core: widths, sine coefficients,
// request and response types and the fixed-point helper functions.
`default_nettype none

package ezyz_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int FW         = FRAC_BITS + 2;

   localparam int NUM_STAGES = 13;
   localparam int STG_CELL0  = 2;
   localparam int NUM_CELLS  = 6;
   localparam int STG_SINE   = STG_CELL0 + NUM_CELLS;
   localparam int STG_FRAC   = STG_SINE + 1;
   localparam int STG_MAT    = STG_FRAC + 1;
   localparam int NUM_LANES  = 6;

   // Lane order of the six sine evaluations.
   localparam int L_SPSI = 0;
   localparam int L_CPSI = 1;
   localparam int L_STH  = 2;
   localparam int L_CTH  = 3;
   localparam int L_SPHI = 4;
   localparam int L_CPHI = 5;

   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
   localparam logic signed [31:0] K13     = 32'sd61;
   localparam logic signed [31:0] K_HORNER [NUM_CELLS] = '{
      32'sd3864, 32'sd172272, 32'sd5026995, 32'sd85569306,
      32'sd693598668, 32'sd1686629713
   };

   typedef struct packed {
      logic signed [15:0] psi_angle;
      logic signed [15:0] theta_angle;
      logic signed [15:0] phi_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] elem_0;
      logic signed [15:0] elem_1;
      logic signed [15:0] elem_2;
      logic signed [15:0] elem_3;
      logic signed [15:0] elem_4;
      logic signed [15:0] elem_5;
      logic signed [15:0] elem_6;
      logic signed [15:0] elem_7;
      logic signed [15:0] elem_8;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         quad;
      logic signed [31:0] t;
      logic signed [31:0] u;
      logic signed [31:0] p;
   } sin_lane_type;

   typedef struct packed {
      logic signed [FW-1:0] spsi;
      logic signed [FW-1:0] cpsi;
      logic signed [FW-1:0] sth;
      logic signed [FW-1:0] cth;
      logic signed [FW-1:0] sphi;
      logic signed [FW-1:0] cphi;
   } trig_type;

   typedef struct packed {
      logic m1;
      logic m2;
      logic m3;
   } mat_ctl_type;

   // Shift right with rounding to nearest, ties away from zero.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic signed [63:0] bias;
      if (s == 0) begin
         return v;
      end
      bias = (64'sd1 <<< (s - 1)) - {63'd0, v[63]};
      return (v + bias) >>> s;
   endfunction

   function automatic logic signed [63:0] mul_wide(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [63:0] ae;
      logic signed [63:0] be;
      ae = 64'(a);
      be = 64'(b);
      return ae * be;
   endfunction

   // Product of two fraction values, scaled back to FRAC_BITS.
   function automatic logic signed [FW-1:0] mul_frac(input logic signed [FW-1:0] a,
                                                     input logic signed [FW-1:0] b);
      return FW'(round_shift(mul_wide(32'(a), 32'(b)), FRAC_BITS));
   endfunction

   // Sign-extended angle placed on a 32-bit full turn.
   function automatic logic [31:0] to_turn(input logic signed [15:0] a);
      logic [63:0] x;
      x = 64'(a);
      return 32'(x << (32 - ANGLE_BITS));
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/euler_zyz_rotation_matrix_core.sv =====
// Top level of the ZYZ Euler-angle rotation matrix core.
// Uses ezyz_pkg, ezyz_sin_cell and ezyz_matrix.
//
// The core takes one request per clock cycle while the response side keeps up,
// and presents each rotation matrix on the response port once the request has
// passed every stage. The pipeline is 13 stages deep, and the first stage
// loads at the accepting edge itself. Two stages fold each angle into a
// quadrant and square its fraction. A chain of six Horner cells evaluates the
// sine polynomial for all six sines and cosines side by side. Two stages
// finish and round the sines, and three stages form the products, sums and
// clamped entries. Each stage has its own valid bit and moves forward whenever
// the stage after it has room, so empty slots close up and requests are still
// accepted while a finished response waits at the output register.
`default_nettype none

module euler_zyz_rotation_matrix_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  ezyz_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output ezyz_pkg::rsp_type rsp_payload
);
   import ezyz_pkg::*;

   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES:0]   rdy;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = rdy[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = v_ff[NUM_STAGES-1];

   // Front stage: angles on a 32-bit turn, cosine as sine a quarter turn on.
   logic [31:0]  turn [NUM_LANES];
   sin_lane_type a_ff [NUM_LANES];
   sin_lane_type a_in [NUM_LANES];
   sin_lane_type b_ff [NUM_LANES];
   sin_lane_type b_in [NUM_LANES];

   always_comb begin
      turn[L_SPSI] = to_turn(req_payload.psi_angle);
      turn[L_STH]  = to_turn(req_payload.theta_angle);
      turn[L_SPHI] = to_turn(req_payload.phi_angle);
      turn[L_CPSI] = turn[L_SPSI] + 32'h4000_0000;
      turn[L_CTH]  = turn[L_STH] + 32'h4000_0000;
      turn[L_CPHI] = turn[L_SPHI] + 32'h4000_0000;
      for (int j = 0; j < NUM_LANES; j++) begin
         a_in[j].quad = turn[j][31:30];
         a_in[j].t    = turn[j][30] ? Q30_ONE - {2'b00, turn[j][29:0]}
                                    : {2'b00, turn[j][29:0]};
         a_in[j].u    = '0;
         a_in[j].p    = '0;
         // Second stage squares the reduced angle and seeds the polynomial.
         b_in[j]      = a_ff[j];
         b_in[j].u    = 32'(round_shift(mul_wide(a_ff[j].t, a_ff[j].t), 30));
         b_in[j].p    = K13;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_ff <= a_in;
      end
      if (rdy[1]) begin
         b_ff <= b_in;
      end
   end

   // Horner chain: one cell per coefficient in each lane.
   sin_lane_type cell_lane [NUM_CELLS+1][NUM_LANES];

   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      assign cell_lane[0][j] = b_ff[j];
      for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
         ezyz_sin_cell u_cell (
            .clock    (clock),
            .load     (rdy[STG_CELL0+i]),
            .coef     (K_HORNER[i]),
            .lane_in  (cell_lane[i][j]),
            .lane_out (cell_lane[i+1][j])
         );
      end
   end

   // Final multiply by the reduced angle, clamp and quadrant sign.
   logic signed [31:0]   s_ff [NUM_LANES];
   logic signed [31:0]   s_in [NUM_LANES];
   logic signed [63:0]   s_raw [NUM_LANES];
   logic signed [FW-1:0] f_in [NUM_LANES];
   trig_type             trig_ff;
   trig_type             trig_in;

   always_comb begin
      for (int j = 0; j < NUM_LANES; j++) begin
         s_raw[j] = round_shift(mul_wide(cell_lane[NUM_CELLS][j].t,
                                         cell_lane[NUM_CELLS][j].p), 30);
         if (s_raw[j] > 64'(Q30_ONE)) begin
            s_in[j] = Q30_ONE;
         end else if (s_raw[j] < 64'sd0) begin
            s_in[j] = '0;
         end else begin
            s_in[j] = 32'(s_raw[j]);
         end
         if (cell_lane[NUM_CELLS][j].quad[1]) begin
            s_in[j] = -s_in[j];
         end
         f_in[j] = FW'(round_shift(64'(s_ff[j]), 30 - FRAC_BITS));
      end
      trig_in.spsi = f_in[L_SPSI];
      trig_in.cpsi = f_in[L_CPSI];
      trig_in.sth  = f_in[L_STH];
      trig_in.cth  = f_in[L_CTH];
      trig_in.sphi = f_in[L_SPHI];
      trig_in.cphi = f_in[L_CPHI];
   end

   always_ff @(posedge clock) begin
      if (rdy[STG_SINE]) begin
         s_ff <= s_in;
      end
      if (rdy[STG_FRAC]) begin
         trig_ff <= trig_in;
      end
   end

   mat_ctl_type mat_ctl;

   assign mat_ctl.m1 = rdy[STG_MAT];
   assign mat_ctl.m2 = rdy[STG_MAT+1];
   assign mat_ctl.m3 = rdy[STG_MAT+2];

   ezyz_matrix u_matrix (
      .clock   (clock),
      .ctl     (mat_ctl),
      .trig_in (trig_ff),
      .rsp_out (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ezyz_sin_cell.sv =====
// One Horner step of the sine polynomial for one lane: p = K - round(p * u).
// Uses ezyz_pkg for the lane type and the rounding helpers.
`default_nettype none

module ezyz_sin_cell (
   input  wire                   clock,
   input  wire                   load,
   input  wire logic signed [31:0] coef,
   input  ezyz_pkg::sin_lane_type lane_in,
   output ezyz_pkg::sin_lane_type lane_out
);
   import ezyz_pkg::*;

   sin_lane_type lane_ff;
   sin_lane_type lane_in_c;

   always_comb begin
      lane_in_c   = lane_in;
      lane_in_c.p = coef - 32'(round_shift(mul_wide(lane_in.p, lane_in.u), 30));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ezyz_matrix.sv =====
// Three-stage matrix builder: pair products, triple products, sums with clamp.
// Uses ezyz_pkg for the fraction format and the response type.
`default_nettype none

module ezyz_matrix (
   input  wire                  clock,
   input  ezyz_pkg::mat_ctl_type ctl,
   input  ezyz_pkg::trig_type    trig_in,
   output ezyz_pkg::rsp_type     rsp_out
);
   import ezyz_pkg::*;

   localparam logic signed [FW:0] LIM = (FW+1)'(1) <<< FRAC_BITS;

   function automatic logic [15:0] finish(input logic signed [FW:0] v);
      logic signed [FW:0] c;
      c = v;
      if (v > LIM) begin
         c = LIM;
      end
      if (v < -LIM) begin
         c = -LIM;
      end
      return 16'(c);
   endfunction

   // First stage: the products of two sines or cosines that the entries need.
   logic signed [FW-1:0] cc_ff, sc_ff, ss_ff, cs_ff, q2_ff, q5_ff, q6_ff, q7_ff;
   logic signed [FW-1:0] r3_ff, r4_ff, cpsi1_ff, spsi1_ff, cth1_ff;
   // Second stage: products with the third factor.
   logic signed [FW-1:0] a0_ff, a1_ff, a3_ff, a4_ff;
   logic signed [FW-1:0] ss2_ff, cs2_ff, q22_ff, q52_ff, q62_ff, q72_ff;
   logic signed [FW-1:0] r32_ff, r42_ff, cth2_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (ctl.m1) begin
         cc_ff    <= mul_frac(trig_in.cphi, trig_in.cth);
         sc_ff    <= mul_frac(trig_in.sphi, trig_in.cth);
         ss_ff    <= mul_frac(trig_in.sphi, trig_in.spsi);
         cs_ff    <= mul_frac(trig_in.cphi, trig_in.spsi);
         q2_ff    <= mul_frac(trig_in.sth, trig_in.cpsi);
         q5_ff    <= mul_frac(trig_in.sth, trig_in.spsi);
         q6_ff    <= mul_frac(trig_in.cphi, trig_in.sth);
         q7_ff    <= mul_frac(trig_in.sphi, trig_in.sth);
         r3_ff    <= mul_frac(trig_in.sphi, trig_in.cpsi);
         r4_ff    <= mul_frac(trig_in.cphi, trig_in.cpsi);
         cpsi1_ff <= trig_in.cpsi;
         spsi1_ff <= trig_in.spsi;
         cth1_ff  <= trig_in.cth;
      end
      if (ctl.m2) begin
         a0_ff   <= mul_frac(cc_ff, cpsi1_ff);
         a1_ff   <= mul_frac(sc_ff, cpsi1_ff);
         a3_ff   <= mul_frac(cc_ff, spsi1_ff);
         a4_ff   <= mul_frac(sc_ff, spsi1_ff);
         ss2_ff  <= ss_ff;
         cs2_ff  <= cs_ff;
         q22_ff  <= q2_ff;
         q52_ff  <= q5_ff;
         q62_ff  <= q6_ff;
         q72_ff  <= q7_ff;
         r32_ff  <= r3_ff;
         r42_ff  <= r4_ff;
         cth2_ff <= cth1_ff;
      end
      if (ctl.m3) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.elem_0 = finish((FW+1)'(a0_ff) - (FW+1)'(ss2_ff));
      rsp_in.elem_1 = finish((FW+1)'(a1_ff) + (FW+1)'(cs2_ff));
      rsp_in.elem_2 = finish((FW+1)'(0) - (FW+1)'(q22_ff));
      rsp_in.elem_3 = finish((FW+1)'(0) - (FW+1)'(a3_ff) - (FW+1)'(r32_ff));
      rsp_in.elem_4 = finish((FW+1)'(r42_ff) - (FW+1)'(a4_ff));
      rsp_in.elem_5 = finish((FW+1)'(q52_ff));
      rsp_in.elem_6 = finish((FW+1)'(q62_ff));
      rsp_in.elem_7 = finish((FW+1)'(q72_ff));
      rsp_in.elem_8 = finish((FW+1)'(cth2_ff));
   end

   assign rsp_out = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ezyz_checker.sv =====
// Port-level checker for the ZYZ rotation matrix core, bound to the top level.
// Uses ezyz_pkg for the response type and the shared assertion macros.
`default_nettype none
`include "euler_zyz_rotation_matrix_core_defines.svh"

module ezyz_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input ezyz_pkg::rsp_type rsp_payload
);
   import ezyz_pkg::*;

   logic entries_in_range;
   logic ready_when_empty;

   // Every entry is a clamped rotation value, within plus or minus one.
   always_comb begin
      entries_in_range =
         (rsp_payload.elem_0 <= 16'sd16384) && (rsp_payload.elem_0 >= -16'sd16384) &&
         (rsp_payload.elem_1 <= 16'sd16384) && (rsp_payload.elem_1 >= -16'sd16384) &&
         (rsp_payload.elem_2 <= 16'sd16384) && (rsp_payload.elem_2 >= -16'sd16384) &&
         (rsp_payload.elem_3 <= 16'sd16384) && (rsp_payload.elem_3 >= -16'sd16384) &&
         (rsp_payload.elem_4 <= 16'sd16384) && (rsp_payload.elem_4 >= -16'sd16384) &&
         (rsp_payload.elem_5 <= 16'sd16384) && (rsp_payload.elem_5 >= -16'sd16384) &&
         (rsp_payload.elem_6 <= 16'sd16384) && (rsp_payload.elem_6 >= -16'sd16384) &&
         (rsp_payload.elem_7 <= 16'sd16384) && (rsp_payload.elem_7 >= -16'sd16384) &&
         (rsp_payload.elem_8 <= 16'sd16384) && (rsp_payload.elem_8 >= -16'sd16384);
      ready_when_empty = !rsp_valid || rsp_ready;
   end

   `EZYZ_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp_payload)
   `EZYZ_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid, "response after reset")
   `EZYZ_ASSERT_WHEN(a_range, rsp_valid, entries_in_range, "entry beyond plus or minus one")
   `EZYZ_ASSERT_WHEN(a_ready, ready_when_empty, req_ready, "request refused with room")

endmodule

bind euler_zyz_rotation_matrix_core ezyz_checker u_ezyz_checker (.*);

`default_nettype wire

// ===== bench/euler_zyz_rotation_matrix_core_tb.sv =====
// Testbench of the ZYZ Euler-angle rotation matrix core: directed and random
// angle triples, checked against a fixed-point rotation predictor in the bench.
// Depends on ezyz_pkg and euler_zyz_rotation_matrix_core.
`default_nettype none

module euler_zyz_rotation_matrix_core_tb;
   import ezyz_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 60;
   localparam int RANDOM_ITEMS = 1100;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   euler_zyz_rotation_matrix_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // Requests waiting to be offered and matrices waiting to come back.
   req_type angle_queue[$];
   rsp_type matrix_queue[$];

   // Idle percentages for each side; changed by the stimulus phases.
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   int  hold_count;
   int  mismatches;
   int  accepted_reqs;
   int  checked_rsps;
   int  idle_cycles;
   bit  stim_done;

   // ---------------------------------------------------------------------
   // Predictor. Sine is an odd Taylor polynomial in Q30 evaluated by
   // Horner's rule, every product rounded to nearest with ties away from
   // zero; cosine is the sine a quarter turn later.
   // ---------------------------------------------------------------------
   function automatic longint rnd_shift(longint v, int s);
      longint mag;
      if (s == 0) begin
         return v;
      end
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint prod_round(longint a, longint b, int s);
      return rnd_shift(a * b, s);
   endfunction

   function automatic longint sine_q30(bit [31:0] ang);
      longint coef[7];
      longint frac_t;
      longint sq;
      longint poly;
      longint s;
      coef = '{61, 3864, 172272, 5026995, 85569306, 693598668, 1686629713};
      frac_t = longint'(ang[29:0]);
      if (ang[30]) begin
         frac_t = longint'(1) * 1073741824 - frac_t;
      end
      sq = prod_round(frac_t, frac_t, 30);
      poly = coef[0];
      for (int k = 1; k < 7; k++) begin
         poly = coef[k] - prod_round(poly, sq, 30);
      end
      s = prod_round(frac_t, poly, 30);
      if (s > 1073741824) begin
         s = 1073741824;
      end
      if (s < 0) begin
         s = 0;
      end
      return ang[31] ? -s : s;
   endfunction

   function automatic bit [31:0] angle_turn(logic signed [15:0] a);
      bit [63:0] x;
      x = 64'(a);
      return 32'(x << (32 - ANGLE_BITS));
   endfunction

   function automatic logic signed [15:0] clamp_entry(longint v);
      longint lim;
      lim = longint'(1) << FRAC_BITS;
      if (v > lim) begin
         v = lim;
      end
      if (v < -lim) begin
         v = -lim;
      end
      return 16'(v);
   endfunction

   function automatic rsp_type rotation_matrix(req_type r);
      bit [31:0] apsi, ath, aphi;
      longint spsi, cpsi, sth, cth, sphi, cphi, cc, sc;
      int fb;
      rsp_type m;
      fb   = FRAC_BITS;
      apsi = angle_turn(r.psi_angle);
      ath  = angle_turn(r.theta_angle);
      aphi = angle_turn(r.phi_angle);
      spsi = rnd_shift(sine_q30(apsi), 30 - fb);
      cpsi = rnd_shift(sine_q30(apsi + 32'h4000_0000), 30 - fb);
      sth  = rnd_shift(sine_q30(ath), 30 - fb);
      cth  = rnd_shift(sine_q30(ath + 32'h4000_0000), 30 - fb);
      sphi = rnd_shift(sine_q30(aphi), 30 - fb);
      cphi = rnd_shift(sine_q30(aphi + 32'h4000_0000), 30 - fb);
      cc   = prod_round(cphi, cth, fb);
      sc   = prod_round(sphi, cth, fb);
      m.elem_0 = clamp_entry(prod_round(cc, cpsi, fb) - prod_round(sphi, spsi, fb));
      m.elem_1 = clamp_entry(prod_round(sc, cpsi, fb) + prod_round(cphi, spsi, fb));
      m.elem_2 = clamp_entry(-prod_round(sth, cpsi, fb));
      m.elem_3 = clamp_entry(-prod_round(cc, spsi, fb) - prod_round(sphi, cpsi, fb));
      m.elem_4 = clamp_entry(-prod_round(sc, spsi, fb) + prod_round(cphi, cpsi, fb));
      m.elem_5 = clamp_entry(prod_round(sth, spsi, fb));
      m.elem_6 = clamp_entry(prod_round(cphi, sth, fb));
      m.elem_7 = clamp_entry(prod_round(sphi, sth, fb));
      m.elem_8 = clamp_entry(cth);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset. Reset is held at the start only.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver. A request leaves the queue only when it is accepted; the
   // payload stays put while valid waits for ready. A new valid is decided
   // only after the previous request has gone, so valid never drops early.
   // ---------------------------------------------------------------------
   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            // The predictor runs on the request just taken by the core.
            matrix_queue.push_back(rotation_matrix(req_payload));
            accepted_reqs++;
            void'(angle_queue.pop_front());
         end
         if (!req_valid || req_ready) begin
            // Offer the next pending request, or idle by the current odds.
            if (angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= angle_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. Each response is compared field by field with the oldest
   // predicted matrix. Ready is drawn fresh every cycle; during a hold-off
   // it stays low for a fixed stretch so the pipeline fills and stalls.
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_rsps++;
            if (matrix_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: response with no request outstanding: %p", rsp_payload);
               end
            end else begin
               want = matrix_queue.pop_front();
               if (want !== rsp_payload) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     for (int k = 0; k < 9; k++) begin
                        if (want[143-16*k -: 16] !== rsp_payload[143-16*k -: 16]) begin
                           $display("ERROR: elem_%0d expected %0d got %0d", k,
                                    $signed(want[143-16*k -: 16]),
                                    $signed(rsp_payload[143-16*k -: 16]));
                        end
                     end
                  end
               end
            end
         end
         if (hold_off && hold_count < HOLD_CYCLES) begin
            rsp_ready  <= 1'b0;
            hold_count <= hold_count + 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake on either side ends
   // the run as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("euler_zyz_rotation_matrix_core test failed");
            $finish;
         end
      end
   end

   // Picks one random angle, with a bias toward quadrant
   // boundaries where the sine folding and clamping matter most.
   function automatic logic signed [15:0] pick_angle();
      logic [15:0] a;
      case ($urandom_range(3))
         0: a = 16'($urandom_range(3) * 16384 + $urandom_range(6) - 3);
         default: a = 16'($urandom);
      endcase
      return a;
   endfunction

   function automatic req_type angle_triple(int psi, int th, int phi);
      req_type r;
      r.psi_angle   = 16'(psi);
      r.theta_angle = 16'(th);
      r.phi_angle   = 16'(phi);
      return r;
   endfunction

   task automatic drain();
      while (angle_queue.size() != 0 || matrix_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_phase(int count, int s_idle, int r_idle);
      req_type r;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++) begin
         r.psi_angle   = pick_angle();
         r.theta_angle = pick_angle();
         r.phi_angle   = pick_angle();
         angle_queue.push_back(r);
      end
      drain();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus. The directed part covers the zero angle, the quarter-turn
   // points, the half-turn wrap at the most negative angle, the largest
   // positive angle and one-step neighbors of the quadrant boundaries.
   // ---------------------------------------------------------------------
   initial begin
      int specials[10];
      mismatches    = 0;
      accepted_reqs = 0;
      checked_rsps  = 0;
      hold_off      = 1'b0;
      stim_done     = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      specials = '{0, 16384, -16384, -32768, 32767, 1, -1, 16383, 16385, 8192};
      @(negedge reset);
      @(posedge clock);
      foreach (specials[k]) begin
         angle_queue.push_back(angle_triple(specials[k], specials[k], specials[k]));
      end
      angle_queue.push_back(angle_triple(16384, 0, -16384));
      angle_queue.push_back(angle_triple(-32768, 16384, 32767));
      angle_queue.push_back(angle_triple(0, 8192, 16384));
      angle_queue.push_back(angle_triple(-16384, -8192, 0));
      angle_queue.push_back(angle_triple(32767, -32768, 1));
      angle_queue.push_back(angle_triple(-1, 16383, -16385));
      angle_queue.push_back(angle_triple(16'h5555, 16'hAAAA, 16'h7FFF));
      angle_queue.push_back(angle_triple(16'hAAAA, 16'h5555, 16'h8000));
      drain();

      // Sustained back-pressure: the receiver holds off while requests keep
      // coming, so the pipeline fills and the input stalls.
      hold_off = 1'b1;
      random_phase(80, 0, 0);
      hold_off = 1'b0;

      random_phase(RANDOM_ITEMS / 3, 28, 82);
      random_phase(RANDOM_ITEMS / 3, 82, 28);
      random_phase(RANDOM_ITEMS / 3, 0, 0);

      // Let any stray response show up before closing.
      repeat (40) @(posedge clock);
      $display("Covered %0d requests with %0d responses checked: boundary angles,",
               accepted_reqs, checked_rsps);
      $display("random triples, both idling mixes and a long output stall.");
      if (mismatches == 0 && matrix_queue.size() == 0) begin
         $display("euler_zyz_rotation_matrix_core test passed");
      end else begin
         $display("%0d mismatches, %0d matrices never returned",
                  mismatches, matrix_queue.size());
         $display("euler_zyz_rotation_matrix_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== euler_zyz_rotation_matrix_core.f =====
+incdir+hw/rtl
hw/rtl/ezyz_pkg.sv
hw/rtl/ezyz_sin_cell.sv
hw/rtl/ezyz_matrix.sv
hw/rtl/euler_zyz_rotation_matrix_core.sv
hw/rtl/ezyz_checker.sv
bench/euler_zyz_rotation_matrix_core_tb.sv
